// ===== design/assert_macros.svh =====
// Shared assertion macros, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in this cycle implies a condition in the next one.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/bcbr_pkg.sv =====
package bcbr_pkg;

    localparam int DEF_MAX_IMAGES   = 2;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_COLS     = 64;
    localparam int DEF_PIXEL_BITS   = 16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] STATUS_INTERP = 2'd0;
    localparam logic [1:0] STATUS_FILL   = 2'd1;
    localparam logic [1:0] STATUS_BAD    = 2'd2;

    localparam logic [2:0] CFG_BATCH_COUNT   = 3'd0;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] CFG_IMAGE_ROWS    = 3'd2;
    localparam logic [2:0] CFG_IMAGE_COLS    = 3'd3;
    localparam logic [2:0] CFG_CROP_ROWS     = 3'd4;
    localparam logic [2:0] CFG_CROP_COLS     = 3'd5;
    localparam logic [2:0] CFG_FILL_VALUE    = 3'd6;

    localparam logic [1:0]        RST_BATCH_COUNT   = 2'd1;
    localparam logic [2:0]        RST_CHANNEL_COUNT = 3'd1;
    localparam logic [6:0]        RST_IMAGE_ROWS    = 7'd64;
    localparam logic [6:0]        RST_IMAGE_COLS    = 7'd64;
    localparam logic [6:0]        RST_CROP_ROWS     = 7'd7;
    localparam logic [6:0]        RST_CROP_COLS     = 7'd7;
    localparam logic signed [15:0] RST_FILL_VALUE   = 16'sd0;

    typedef struct packed {
        logic               operation;
        logic [1:0]         batch_index;
        logic [1:0]         channel;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] pixel_value;
        logic signed [19:0] box_x1;
        logic signed [19:0] box_y1;
        logic signed [19:0] box_x2;
        logic signed [19:0] box_y2;
    } item_t;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic [1:0]         sample_status;
    } result_t;

endpackage

// ===== design/box_crop_bilinear_resample_unit.sv =====
// Crop-and-resize bilinear sampler with an on-chip image store.
// Channels: item (valid/ready) carries write and sample beats, result
// (valid/ready) returns one beat per sample, cfg (valid/ready, always ready)
// writes the seven setup registers by index.
// A write beat returns nothing. A sample beat with a bad batch or channel
// goes straight to the final state; any other sample maps rows, then columns,
// each through a one-bit-per-cycle divider by (crop size - 1), or by 2 for a
// crop size of at most one; a position outside the image returns the fill
// value, else four pixels are read from the single-port store and blended.
// One item is worked on at a time; item_ready is high only when idle.
// The result register lets the next item enter while a finished beat waits;
// a stalled receiver holds the block in its final state until the slot frees.
// Reset clears control and the setup registers to their defaults; the image
// store is not cleared and must be written before it is sampled.
module box_crop_bilinear_resample_unit #(
    parameter int MAX_IMAGES   = bcbr_pkg::DEF_MAX_IMAGES,
    parameter int MAX_CHANNELS = bcbr_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_ROWS     = bcbr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = bcbr_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS   = bcbr_pkg::DEF_PIXEL_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  bcbr_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_ready,
    output bcbr_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

`include "assert_macros.svh"

    localparam int AXW   = ($clog2(MAX_ROWS) > $clog2(MAX_COLS)) ?
                           $clog2(MAX_ROWS) : $clog2(MAX_COLS);
    localparam int QW    = AXW + 16;
    localparam int TW    = 30;
    localparam int NW    = TW + AXW + 1;
    localparam int CNTW  = $clog2(QW);
    localparam int DEPTH = MAX_IMAGES * MAX_CHANNELS * MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PLANE = MAX_ROWS * MAX_COLS;
    localparam int BW    = PIXEL_BITS + 18;
    localparam int VW    = BW + 19;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL1   = 4'd1;
    localparam logic [3:0] ST_MUL2   = 4'd2;
    localparam logic [3:0] ST_CHECK  = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_AXEND  = 4'd5;
    localparam logic [3:0] ST_READ   = 4'd6;
    localparam logic [3:0] ST_BLEND1 = 4'd7;
    localparam logic [3:0] ST_BLEND2 = 4'd8;
    localparam logic [3:0] ST_ROUND  = 4'd9;
    localparam logic [3:0] ST_FIN    = 4'd10;

    logic [1:0]         batch_count_reg;
    logic [2:0]         channel_count_reg;
    logic [6:0]         image_rows_reg, image_cols_reg, crop_rows_reg, crop_cols_reg;
    logic signed [15:0] fill_value_reg;

    logic [3:0]            state_reg;
    logic                  axis_reg;
    bcbr_pkg::item_t       item_reg;
    logic signed [TW-1:0]  t_reg;
    logic signed [NW-1:0]  n_reg;
    logic [AXW+6:0]        lim_reg;
    logic [6:0]            q_reg;
    logic [AXW-1:0]        sm1_reg;
    logic [6:0]            rem_reg;
    logic [QW-1:0]         dvd_reg;
    logic [CNTW-1:0]       div_cnt_reg;
    logic [AXW-1:0]        ty_reg, by_reg, lx_reg, rx_reg;
    logic [15:0]           fy_reg, fx_reg;
    logic [2:0]            rd_cnt_reg;
    logic signed [PIXEL_BITS-1:0] px_reg [4];
    logic signed [BW-1:0]  top_reg, bot_reg;
    logic signed [VW-1:0]  v_reg;
    logic signed [15:0]    res_value_reg;
    logic [1:0]            res_status_reg;
    logic                  result_valid_reg;
    bcbr_pkg::result_t     result_reg;

    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] mem_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [PIXEL_BITS-1:0] mem_wdata;

    // setup registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_count_reg   <= bcbr_pkg::RST_BATCH_COUNT;
            channel_count_reg <= bcbr_pkg::RST_CHANNEL_COUNT;
            image_rows_reg    <= bcbr_pkg::RST_IMAGE_ROWS;
            image_cols_reg    <= bcbr_pkg::RST_IMAGE_COLS;
            crop_rows_reg     <= bcbr_pkg::RST_CROP_ROWS;
            crop_cols_reg     <= bcbr_pkg::RST_CROP_COLS;
            fill_value_reg    <= bcbr_pkg::RST_FILL_VALUE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bcbr_pkg::CFG_BATCH_COUNT:   batch_count_reg   <= cfg_data[1:0];
                bcbr_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[2:0];
                bcbr_pkg::CFG_IMAGE_ROWS:    image_rows_reg    <= cfg_data[6:0];
                bcbr_pkg::CFG_IMAGE_COLS:    image_cols_reg    <= cfg_data[6:0];
                bcbr_pkg::CFG_CROP_ROWS:     crop_rows_reg     <= cfg_data[6:0];
                bcbr_pkg::CFG_CROP_COLS:     crop_cols_reg     <= cfg_data[6:0];
                bcbr_pkg::CFG_FILL_VALUE:    fill_value_reg    <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // axis operands
    logic [6:0]         ax_size, ax_crop, ax_crop1, ax_q;
    logic [AXW-1:0]     ax_sm1;
    logic signed [19:0] ax_e1, ax_e2;
    logic [5:0]         ax_pos;
    logic [31:0]        ax_max;

    always_comb
    begin
        ax_size = axis_reg ? image_cols_reg : image_rows_reg;
        ax_max  = axis_reg ? 32'(MAX_COLS) : 32'(MAX_ROWS);
        ax_crop = axis_reg ? crop_cols_reg : crop_rows_reg;
        ax_e1   = axis_reg ? item_reg.box_x1 : item_reg.box_y1;
        ax_e2   = axis_reg ? item_reg.box_x2 : item_reg.box_y2;
        ax_pos  = axis_reg ? item_reg.col : item_reg.row;
        if (ax_size == 7'd0)
            ax_sm1 = '0;
        else if (32'(ax_size) > ax_max)
            ax_sm1 = AXW'(ax_max - 32'd1);
        else
            ax_sm1 = AXW'(ax_size - 7'd1);
        ax_crop1 = (ax_crop == 7'd0) ? 7'd1 : ax_crop;
        ax_q     = (ax_crop1 > 7'd1) ? ax_crop1 - 7'd1 : 7'd2;
    end

    logic signed [TW-1:0] t_next;
    logic [AXW+6:0]       lim_next;

    always_comb
    begin
        if (ax_crop1 > 7'd1)
            t_next = TW'(ax_e1) * TW'($signed({1'b0, ax_q}))
                   + TW'($signed({1'b0, ax_pos})) * (TW'(ax_e2) - TW'(ax_e1));
        else
            t_next = TW'(ax_e1) + TW'(ax_e2);
        lim_next = (AXW+7)'(ax_sm1) * (AXW+7)'(ax_q);
    end

    logic signed [NW-1:0] n_next, lim_ext;
    assign n_next  = NW'(t_reg) * NW'($signed({1'b0, sm1_reg}));
    assign lim_ext = $signed(NW'({lim_reg, 16'h0000}));

    // divider step
    logic [7:0] div_r8;
    logic       div_ge;
    assign div_r8 = {rem_reg, dvd_reg[QW-1]};
    assign div_ge = div_r8 >= {1'b0, q_reg};

    logic [AXW-1:0] p_lo;
    logic [15:0]    p_frac;
    logic [AXW:0]   p_hi_raw;
    logic [AXW-1:0] p_hi;

    always_comb
    begin
        p_lo     = dvd_reg[QW-1:16];
        p_frac   = dvd_reg[15:0];
        p_hi_raw = {1'b0, p_lo} + ((p_frac != 16'h0000) ? (AXW+1)'(1) : (AXW+1)'(0));
        p_hi     = (p_hi_raw > {1'b0, sm1_reg}) ? sm1_reg : p_hi_raw[AXW-1:0];
    end

    // memory addressing
    logic        item_acc, bad_sel, wr_in_range;
    logic [31:0] wr_addr32, rd_addr32, plane_base;
    logic [AXW-1:0] rd_row, rd_col;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_acc   = item_valid && item_ready;

    always_comb
    begin
        wr_in_range = (32'(item.batch_index) < 32'(MAX_IMAGES))
                   && (32'(item.channel) < 32'(MAX_CHANNELS))
                   && (32'(item.row) < 32'(MAX_ROWS))
                   && (32'(item.col) < 32'(MAX_COLS));
        wr_addr32 = (32'(item.batch_index) * 32'(MAX_CHANNELS) + 32'(item.channel))
                  * 32'(PLANE) + 32'(item.row) * 32'(MAX_COLS) + 32'(item.col);
        bad_sel = (item.batch_index >= batch_count_reg)
               || (32'(item.batch_index) >= 32'(MAX_IMAGES))
               || ({1'b0, item.channel} >= channel_count_reg)
               || (32'(item.channel) >= 32'(MAX_CHANNELS));
        plane_base = (32'(item_reg.batch_index) * 32'(MAX_CHANNELS)
                   + 32'(item_reg.channel)) * 32'(PLANE);
        rd_row = rd_cnt_reg[1] ? by_reg : ty_reg;
        rd_col = rd_cnt_reg[0] ? rx_reg : lx_reg;
        rd_addr32 = plane_base + 32'(rd_row) * 32'(MAX_COLS) + 32'(rd_col);
    end

    logic signed [31:0] px32;
    assign px32      = 32'(item.pixel_value);
    assign mem_wdata = px32[PIXEL_BITS-1:0];
    assign mem_we    = item_acc && (item.operation == bcbr_pkg::OP_WRITE) && wr_in_range;
    assign mem_addr  = (state_reg == ST_IDLE) ? AW'(wr_addr32) : AW'(rd_addr32);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata <= mem[mem_addr];
    end

    // blend and rounding
    logic signed [BW-1:0] top_next, bot_next;
    logic signed [VW-1:0] v_next, v_round;
    logic signed [63:0]   r64;
    logic signed [15:0]   r_clamped;

    always_comb
    begin
        top_next = (BW'(px_reg[0]) <<< 16)
                 + (BW'(px_reg[1]) - BW'(px_reg[0])) * BW'($signed({1'b0, fx_reg}));
        bot_next = (BW'(px_reg[2]) <<< 16)
                 + (BW'(px_reg[3]) - BW'(px_reg[2])) * BW'($signed({1'b0, fx_reg}));
        v_next   = (VW'(top_reg) <<< 16)
                 + (VW'(bot_reg) - VW'(top_reg)) * VW'($signed({1'b0, fy_reg}));
        v_round  = v_reg + $signed({{(VW-32){1'b0}}, 1'b1, 31'h0});
        r64      = 64'($signed(v_round[VW-1:32]));
        if (r64 > 64'sd32767)
            r_clamped = 16'sh7FFF;
        else if (r64 < -64'sd32768)
            r_clamped = -16'sh8000;
        else
            r_clamped = r64[15:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            axis_reg         <= 1'b0;
            div_cnt_reg      <= '0;
            rd_cnt_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc && item.operation == bcbr_pkg::OP_SAMPLE)
                    begin
                        axis_reg <= 1'b0;
                        state_reg <= bad_sel ? ST_FIN : ST_MUL1;
                    end
                end
                ST_MUL1:   state_reg <= ST_MUL2;
                ST_MUL2:   state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= (n_reg < 0 || n_reg > lim_ext) ? ST_FIN : ST_DIV;
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + CNTW'(1);
                    if (div_cnt_reg == CNTW'(QW - 1))
                        state_reg <= ST_AXEND;
                end
                ST_AXEND:
                begin
                    rd_cnt_reg <= '0;
                    axis_reg   <= 1'b1;
                    state_reg  <= axis_reg ? ST_READ : ST_MUL1;
                end
                ST_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg == 3'd4)
                        state_reg <= ST_BLEND1;
                end
                ST_BLEND1: state_reg <= ST_BLEND2;
                ST_BLEND2: state_reg <= ST_ROUND;
                ST_ROUND:  state_reg <= ST_FIN;
                ST_FIN:
                begin
                    // hold until the result slot frees
                    if (!result_valid_reg || result_ready)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                    item_reg <= item;
                res_value_reg  <= 16'sd0;
                res_status_reg <= bcbr_pkg::STATUS_BAD;
            end
            ST_MUL1:
            begin
                t_reg   <= t_next;
                lim_reg <= lim_next;
                q_reg   <= ax_q;
                sm1_reg <= ax_sm1;
            end
            ST_MUL2:   n_reg <= n_next;
            ST_CHECK:
            begin
                rem_reg        <= n_reg[QW+6:QW];
                dvd_reg        <= n_reg[QW-1:0];
                res_value_reg  <= fill_value_reg;
                res_status_reg <= bcbr_pkg::STATUS_FILL;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? 7'(div_r8 - {1'b0, q_reg}) : div_r8[6:0];
                dvd_reg <= {dvd_reg[QW-2:0], div_ge};
            end
            ST_AXEND:
            begin
                if (axis_reg)
                begin
                    lx_reg <= p_lo;
                    rx_reg <= p_hi;
                    fx_reg <= p_frac;
                end
                else
                begin
                    ty_reg <= p_lo;
                    by_reg <= p_hi;
                    fy_reg <= p_frac;
                end
            end
            ST_READ:
            begin
                if (rd_cnt_reg != 3'd0)
                    px_reg[2'(rd_cnt_reg - 3'd1)] <= $signed(mem_rdata);
            end
            ST_BLEND1:
            begin
                top_reg <= top_next;
                bot_reg <= bot_next;
            end
            ST_BLEND2: v_reg <= v_next;
            ST_ROUND:
            begin
                res_value_reg  <= r_clamped;
                res_status_reg <= bcbr_pkg::STATUS_INTERP;
            end
            ST_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_reg.sample_value  <= res_value_reg;
                    result_reg.sample_status <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_ALWAYS(a_result_from_fin,
        $rose(result_valid) |-> $past(state_reg) == ST_FIN,
        "result beat raised outside the final state")
    `ASSERT_ALWAYS(a_div_rem_below_q,
        (state_reg == ST_DIV) |-> (rem_reg < q_reg),
        "divider remainder reached the divisor")
    `ASSERT_ALWAYS(a_pos_in_image,
        (state_reg == ST_AXEND) |-> (p_lo <= sm1_reg),
        "mapped index beyond the image")
    `ASSERT_NEXT(a_read_to_blend,
        (state_reg == ST_READ) && (rd_cnt_reg == 3'd4),
        state_reg == ST_BLEND1,
        "pixel reads did not finish in four beats")

endmodule

// ===== sim/box_crop_bilinear_resample_unit_tb.sv =====
module box_crop_bilinear_resample_unit_tb;
    import bcbr_pkg::*;

    localparam int STORE_SIZE = DEF_MAX_IMAGES * DEF_MAX_CHANNELS * DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // shadow of the setup registers and the pixel store
    logic [1:0]         sh_batches;
    logic [2:0]         sh_channels;
    logic [6:0]         sh_img_rows;
    logic [6:0]         sh_img_cols;
    logic [6:0]         sh_crop_rows;
    logic [6:0]         sh_crop_cols;
    logic signed [15:0] sh_fill;
    logic signed [15:0] pixel_mem [STORE_SIZE];
    bit                 pixel_set [STORE_SIZE];

    result_t sample_q[$];
    int      errors;
    longint  cycles;
    int      burst_left;
    int      stall_mode;
    int      stall_left;

    box_crop_bilinear_resample_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pixel_addr(int b, int c, int r, int k);
        return ((b * DEF_MAX_CHANNELS + c) * DEF_MAX_ROWS + r) * DEF_MAX_COLS + k;
    endfunction

    function automatic longint clamp_dim(longint v, longint hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // map one axis onto the source grid; 0 when the position falls outside
    function automatic bit map_axis(longint e1, longint e2, longint pos, longint size,
                                    longint crop, output longint lo, output longint hi,
                                    output longint frac);
        longint n;
        longint q;
        longint p;
        lo = 0;
        hi = 0;
        frac = 0;
        if (crop > 1)
        begin
            q = crop - 1;
            n = (size - 1) * (e1 * q + pos * (e2 - e1));
        end
        else
        begin
            q = 2;
            n = (size - 1) * (e1 + e2);
        end
        if (n < 0 || n > (size - 1) * 65536 * q)
            return 1'b0;
        p = n / q;
        lo = p >>> 16;
        frac = p & 65535;
        hi = lo + ((frac != 0) ? 1 : 0);
        if (hi > size - 1)
            hi = size - 1;
        return 1'b1;
    endfunction

    // bilinear sample; returns 1 when the four pixels in nb are read
    function automatic bit resample(input item_t it, output result_t r, output int nb[4]);
        longint ty, by, fy, lx, rx, fx;
        longint tl, tr, bl, br, top, bot, v;
        bit     in_y, in_x;
        int     b, c;
        b = it.batch_index;
        c = it.channel;
        nb = '{0, 0, 0, 0};
        if (b >= sh_batches || b >= DEF_MAX_IMAGES || c >= sh_channels
                || c >= DEF_MAX_CHANNELS)
        begin
            r.sample_value = '0;
            r.sample_status = STATUS_BAD;
            return 1'b0;
        end
        in_y = map_axis(it.box_y1, it.box_y2, it.row, clamp_dim(sh_img_rows, DEF_MAX_ROWS),
                        clamp_dim(sh_crop_rows, 127), ty, by, fy);
        in_x = map_axis(it.box_x1, it.box_x2, it.col, clamp_dim(sh_img_cols, DEF_MAX_COLS),
                        clamp_dim(sh_crop_cols, 127), lx, rx, fx);
        if (!in_y || !in_x)
        begin
            r.sample_value = sh_fill;
            r.sample_status = STATUS_FILL;
            return 1'b0;
        end
        nb[0] = pixel_addr(b, c, ty, lx);
        nb[1] = pixel_addr(b, c, ty, rx);
        nb[2] = pixel_addr(b, c, by, lx);
        nb[3] = pixel_addr(b, c, by, rx);
        tl = pixel_mem[nb[0]];
        tr = pixel_mem[nb[1]];
        bl = pixel_mem[nb[2]];
        br = pixel_mem[nb[3]];
        top = tl * 65536 + (tr - tl) * fx;
        bot = bl * 65536 + (br - bl) * fx;
        v = top * 65536 + (bot - top) * fy;
        v = (v + 64'sh8000_0000) >>> 32;
        r.sample_value = v[15:0];
        r.sample_status = STATUS_INTERP;
        return 1'b1;
    endfunction

    function automatic item_t mk(logic op, int b, int c, int r, int k, int pix,
                                 int x1, int y1, int x2, int y2);
        item_t it;
        it.operation = op;
        it.batch_index = b;
        it.channel = c;
        it.row = r;
        it.col = k;
        it.pixel_value = pix;
        it.box_x1 = x1;
        it.box_y1 = y1;
        it.box_x2 = x2;
        it.box_y2 = y2;
        return it;
    endfunction

    // drive one beat, wait for the handshake, then update the prediction
    task automatic push_beat(item_t it, bit typed, result_t want);
        result_t r;
        int      nb[4];
        bit      reads;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        item = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (it.operation == OP_WRITE)
        begin
            if (it.batch_index < DEF_MAX_IMAGES)
            begin
                pixel_mem[pixel_addr(it.batch_index, it.channel, it.row, it.col)] =
                    it.pixel_value;
                pixel_set[pixel_addr(it.batch_index, it.channel, it.row, it.col)] = 1'b1;
            end
        end
        else
        begin
            reads = resample(it, r, nb);
            sample_q.push_back(typed ? want : r);
        end
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // write any neighbor pixel still unset first, so no sample reads garbage
    task automatic push_sample(item_t it, bit typed, result_t want);
        result_t r;
        int      nb[4];
        int      a;
        if (resample(it, r, nb))
        begin
            for (int i = 0; i < 4; i++)
            begin
                a = nb[i];
                if (!pixel_set[a])
                    push_beat(mk(OP_WRITE, a >> 14, (a >> 12) & 3, (a >> 6) & 63, a & 63,
                                 $urandom_range(0, 65535), 0, 0, 0, 0), 1'b0, r);
            end
        end
        push_beat(it, typed, want);
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BATCH_COUNT:   sh_batches = val[1:0];
            CFG_CHANNEL_COUNT: sh_channels = val[2:0];
            CFG_IMAGE_ROWS:    sh_img_rows = val[6:0];
            CFG_IMAGE_COLS:    sh_img_cols = val[6:0];
            CFG_CROP_ROWS:     sh_crop_rows = val[6:0];
            CFG_CROP_COLS:     sh_crop_cols = val[6:0];
            CFG_FILL_VALUE:    sh_fill = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int rand_edge();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return $urandom_range(0, 65536);
        if (sel < 17)
            return $urandom_range(0, 105536) - 20000;
        return $urandom_range(0, 1048575) - 524288;
    endfunction

    task automatic random_phase(int count);
        item_t   it;
        result_t none;
        int      crop_r;
        int      crop_c;
        none = '0;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2 && $urandom_range(0, 1) == 1)
                while (sample_q.size() != 0)
                    @(negedge clk);
            crop_r = clamp_dim(sh_crop_rows, 64);
            crop_c = clamp_dim(sh_crop_cols, 64);
            if ($urandom_range(0, 9) < 2)
            begin
                push_beat(mk(OP_WRITE, $urandom_range(0, 3), $urandom_range(0, 3),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 65535), rand_edge(), rand_edge(),
                             rand_edge(), rand_edge()), 1'b0, none);
                continue;
            end
            it = mk(OP_SAMPLE, 0, 0, 0, 0, $urandom_range(0, 65535),
                    rand_edge(), rand_edge(), rand_edge(), rand_edge());
            if ($urandom_range(0, 19) < 17)
            begin
                it.batch_index = $urandom_range(0, (sh_batches > 1) ? sh_batches - 1 : 0);
                it.channel = $urandom_range(0, (sh_channels > 1) ? sh_channels - 1 : 0);
                it.row = $urandom_range(0, crop_r - 1);
                it.col = $urandom_range(0, crop_c - 1);
            end
            else
            begin
                it.batch_index = $urandom_range(0, 3);
                it.channel = $urandom_range(0, 3);
                it.row = $urandom_range(0, 63);
                it.col = $urandom_range(0, 63);
            end
            if ($urandom_range(0, 19) == 0)
                it.box_y2 = it.box_y1;
            push_sample(it, 1'b0, none);
        end
    endtask

    // receiver backpressure: switch among patterns every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= $urandom_range(0, 1);
            2:       result_ready <= ($urandom_range(0, 7) == 0);
            default: result_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (sample_q.size() == 0)
            begin
                $display("%0t: unexpected result value %h status %0d", $time,
                         result.sample_value, result.sample_status);
                errors++;
            end
            else
            begin
                if (result.sample_value !== sample_q[0].sample_value)
                begin
                    $display("%0t: sample_value expected %h actual %h", $time,
                             sample_q[0].sample_value, result.sample_value);
                    errors++;
                end
                if (result.sample_status !== sample_q[0].sample_status)
                begin
                    $display("%0t: sample_status expected %0d actual %0d", $time,
                             sample_q[0].sample_status, result.sample_status);
                    errors++;
                end
                void'(sample_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[box_crop_bilinear_resample_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[14];
        result_t   bad_res;
        result_t   fill_res;
        result_t   r;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BATCH_COUNT;
        cfg_data = '0;
        sh_batches = RST_BATCH_COUNT;
        sh_channels = RST_CHANNEL_COUNT;
        sh_img_rows = RST_IMAGE_ROWS;
        sh_img_cols = RST_IMAGE_COLS;
        sh_crop_rows = RST_CROP_ROWS;
        sh_crop_cols = RST_CROP_COLS;
        sh_fill = RST_FILL_VALUE;
        foreach (pixel_set[i])
        begin
            pixel_set[i] = 1'b0;
            pixel_mem[i] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        bad_res.sample_value = '0;
        bad_res.sample_status = STATUS_BAD;
        fill_res.sample_value = '0;
        fill_res.sample_status = STATUS_FILL;
        r = '0;
        rows[0]  = '{mk(OP_SAMPLE, 1, 0, 0, 0, 0, 0, 0, 65536, 65536), 1'b1, bad_res};
        rows[1]  = '{mk(OP_SAMPLE, 0, 1, 0, 0, 0, 0, 0, 65536, 65536), 1'b1, bad_res};
        rows[2]  = '{mk(OP_SAMPLE, 3, 3, 63, 63, -1, 0, 0, 0, 0), 1'b1, bad_res};
        rows[3]  = '{mk(OP_SAMPLE, 0, 0, 0, 0, 0, -524288, -524288, -524288, -524288),
                     1'b1, fill_res};
        rows[4]  = '{mk(OP_SAMPLE, 0, 0, 3, 3, 0, 524287, 524287, 524287, 524287),
                     1'b1, fill_res};
        rows[5]  = '{mk(OP_WRITE, 0, 0, 0, 0, 32767, 0, 0, 0, 0), 1'b0, r};
        rows[6]  = '{mk(OP_WRITE, 0, 0, 63, 63, -32768, 0, 0, 0, 0), 1'b0, r};
        rows[7]  = '{mk(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{16'sd32767, STATUS_INTERP}};
        rows[8]  = '{mk(OP_SAMPLE, 0, 0, 6, 6, 0, 65536, 65536, 65536, 65536), 1'b1,
                     '{-16'sd32768, STATUS_INTERP}};
        rows[9]  = '{mk(OP_WRITE, 3, 3, 63, 63, 16'h5555, 0, 0, 0, 0), 1'b0, r};
        rows[10] = '{mk(OP_WRITE, 1, 3, 42, 21, -1, 0, 0, 0, 0), 1'b0, r};
        rows[11] = '{mk(OP_SAMPLE, 0, 0, 3, 3, 0, 0, 0, 65536, 65536), 1'b0, r};
        rows[12] = '{mk(OP_SAMPLE, 0, 0, 63, 63, 0, 0, 0, 65536, 65536), 1'b1, fill_res};
        rows[13] = '{mk(OP_SAMPLE, 0, 0, 2, 5, 0, 32768, 32768, 32768, 32768), 1'b0, r};
        foreach (rows[i])
        begin
            if (rows[i].beat.operation == OP_SAMPLE)
                push_sample(rows[i].beat, rows[i].typed, rows[i].want);
            else
                push_beat(rows[i].beat, 1'b0, r);
        end

        random_phase(240);

        wait_idle();
        write_reg(CFG_BATCH_COUNT, 16'd2);
        write_reg(CFG_CHANNEL_COUNT, 16'd4);
        write_reg(CFG_IMAGE_ROWS, 16'd64);
        write_reg(CFG_IMAGE_COLS, 16'd64);
        write_reg(CFG_CROP_ROWS, 16'd1);
        write_reg(CFG_CROP_COLS, 16'd1);
        write_reg(CFG_FILL_VALUE, 16'h7FFF);
        random_phase(260);

        wait_idle();
        write_reg(CFG_IMAGE_ROWS, 16'd1);
        write_reg(CFG_IMAGE_COLS, 16'd1);
        write_reg(CFG_CROP_ROWS, 16'd64);
        write_reg(CFG_CROP_COLS, 16'd64);
        write_reg(CFG_FILL_VALUE, 16'h8000);
        random_phase(200);

        wait_idle();
        write_reg(CFG_BATCH_COUNT, 16'hFFFF);
        write_reg(CFG_CHANNEL_COUNT, 16'hFFFF);
        write_reg(CFG_IMAGE_ROWS, 16'd127);
        write_reg(CFG_IMAGE_COLS, 16'd127);
        write_reg(CFG_CROP_ROWS, 16'd0);
        write_reg(CFG_CROP_COLS, 16'd127);
        write_reg(CFG_FILL_VALUE, 16'h1234);
        random_phase(220);

        wait_idle();
        write_reg(CFG_BATCH_COUNT, 16'd0);
        write_reg(CFG_CHANNEL_COUNT, 16'd0);
        write_reg(CFG_IMAGE_ROWS, 16'd5);
        write_reg(CFG_IMAGE_COLS, 16'd3);
        write_reg(CFG_CROP_ROWS, 16'd2);
        write_reg(CFG_CROP_COLS, 16'd3);
        write_reg(CFG_FILL_VALUE, 16'h0000);
        random_phase(80);

        wait_idle();
        write_reg(CFG_BATCH_COUNT, 16'd2);
        write_reg(CFG_CHANNEL_COUNT, 16'd3);
        write_reg(CFG_IMAGE_ROWS, 16'd0);
        write_reg(CFG_IMAGE_COLS, 16'd64);
        write_reg(CFG_CROP_ROWS, 16'd5);
        write_reg(CFG_CROP_COLS, 16'd1);
        write_reg(CFG_FILL_VALUE, 16'hFFFB);
        random_phase(300);

        wait_idle();
        write_reg(CFG_CHANNEL_COUNT, 16'd4);
        write_reg(CFG_IMAGE_ROWS, 16'd17);
        write_reg(CFG_IMAGE_COLS, 16'd9);
        write_reg(CFG_CROP_ROWS, 16'd9);
        write_reg(CFG_CROP_COLS, 16'd64);
        write_reg(CFG_FILL_VALUE, 16'd100);
        random_phase(340);

        wait_idle();
        if (errors == 0)
            $display("[box_crop_bilinear_resample_unit] OK");
        else
            $display("[box_crop_bilinear_resample_unit] ERROR");
        $finish;
    end
endmodule

// ===== box_crop_bilinear_resample_unit.f =====
+incdir+design
design/bcbr_pkg.sv
design/box_crop_bilinear_resample_unit.sv
sim/box_crop_bilinear_resample_unit_tb.sv
